@@ rtl/dedb_pkg.sv @@
// Shared types, constants and helpers for the deduplicating event buffer.
// No dependencies; imported by every module of the block.
package dedb_pkg;

    localparam int SLOTS_DEF     = 32;
    localparam int MAX_BYTES_DEF = 8;

    // result kinds
    localparam logic [2:0] KIND_STORED = 3'd0;
    localparam logic [2:0] KIND_DUP    = 3'd1;
    localparam logic [2:0] KIND_FULL   = 3'd2;
    localparam logic [2:0] KIND_EMIT   = 3'd3;
    localparam logic [2:0] KIND_IDLE   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_FLUSH_PERIOD = 2'd0;
    localparam logic [1:0] CFG_OVF_LEVEL    = 2'd1;
    localparam logic [1:0] CFG_OVF_MODULE   = 2'd2;

    localparam logic [7:0] FLUSH_PERIOD_RST = 8'd20;
    localparam logic [7:0] OVF_LEVEL_RST    = 8'd1;
    localparam logic [7:0] OVF_MODULE_RST   = 8'd0;

    // overflow marker entry
    localparam logic [7:0]  OVF_FUNC = 8'd24;
    localparam logic [3:0]  OVF_LEN  = 4'd4;
    localparam logic [63:0] OVF_PAY  = 64'd1;

    typedef struct packed {
        logic [3:0] len;
        logic [7:0] func;
        logic [7:0] modl;
        logic [7:0] lev;
    } hdr_t;

    // ones over the first len bytes
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        if (len >= 4'd8) begin
            m = '1;
        end else begin
            m = ~({64{1'b1}} << {len[2:0], 3'b000});
        end
        return m;
    endfunction

endpackage

@@ rtl/dedb_slot_mem.sv @@
// Slot table storage: header and payload memories, one write and one read port.
// Depends on dedb_pkg for the header type.
module dedb_slot_mem import dedb_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IW   = $clog2(SLOTS)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  hdr_t          whdr,
    input  logic [63:0]   wpay,
    input  logic [IW-1:0] raddr,
    output hdr_t          rhdr,
    output logic [63:0]   rpay
);

    hdr_t        hdr_mem [SLOTS];
    logic [63:0] pay_mem [SLOTS];
    hdr_t        rhdr_reg;
    logic [63:0] rpay_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            hdr_mem[waddr] <= whdr;
            pay_mem[waddr] <= wpay;
        end
    end

    always_ff @(posedge aclk) begin
        rhdr_reg <= hdr_mem[raddr];
        rpay_reg <= pay_mem[raddr];
    end

    assign rhdr = rhdr_reg;
    assign rpay = rpay_reg;

endmodule

@@ rtl/dedb_match.sv @@
// Shared compare unit: duplicate test of a stored slot against the posted event,
// and the length-masked payload of the slot for emission. Depends on dedb_pkg.
module dedb_match import dedb_pkg::*; (
    input  logic [7:0]  key_lev,
    input  logic [7:0]  key_mod,
    input  logic [7:0]  key_func,
    input  logic [63:0] key_pay,
    input  hdr_t        st_hdr,
    input  logic [63:0] st_pay,
    output logic        hit,
    output logic [63:0] emit_pay
);

    logic [63:0] mask;

    // compare runs over the stored entry's own byte count
    assign mask     = byte_mask(st_hdr.len);
    assign emit_pay = st_pay & mask;
    assign hit      = (st_hdr.lev == key_lev) && (st_hdr.modl == key_mod)
                   && (st_hdr.func == key_func) && (((st_pay ^ key_pay) & mask) == 64'd0);

endmodule

@@ rtl/dedup_event_buffer.sv @@
// Deduplicating event buffer. Post: the table is scanned through the slot memory port,
// one slot read per cycle, then the result goes to the result register; a post into a
// full table and a tick go straight to the result register; flush: one cycle per empty
// slot, and each emitted beat waits out any output stall.
// One item at a time; a finished result may wait in the output register.
// Reset (synchronous, aresetn low) clears valid bits and counters and loads the
// register defaults; slot memory contents are left undefined, no clearing pass.
module dedup_event_buffer import dedb_pkg::*; #(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_level,
    input  logic [7:0]  s_module_req,
    input  logic [7:0]  s_func_code,
    input  logic [3:0]  s_data_len,
    input  logic [63:0] s_payload,
    input  logic        s_link_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_out_level,
    output logic [7:0]  m_out_module,
    output logic [7:0]  m_out_func,
    output logic [3:0]  m_out_len,
    output logic [63:0] m_out_payload,
    output logic        m_last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [IW-1:0] SCAN_END = IW'(SLOTS - 2);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RESP = 3'd2;
    localparam logic [2:0] ST_FRD  = 3'd3;
    localparam logic [2:0] ST_FEM  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IW-1:0]    addr_reg, addr_next;
    logic [IW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             free_found_reg, free_found_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [IW-1:0]    used_reg, used_next;
    logic [7:0]       tick_reg, tick_next;
    logic [2:0]       res_kind_reg, res_kind_next;

    logic [7:0] period_reg, ovf_lev_reg, ovf_mod_reg;

    // latched input beat
    logic [7:0]  in_lev_reg, in_mod_reg, in_func_reg;
    logic [3:0]  in_len_reg;
    logic [63:0] in_pay_reg;
    logic [3:0]  len_clamp;

    logic        m_valid_reg;
    logic [2:0]  m_kind_reg;
    hdr_t        m_hdr_reg;
    logic [63:0] m_pay_reg;
    logic        m_last_reg;

    logic        out_free, out_load;
    logic [2:0]  o_kind;
    hdr_t        o_hdr;
    logic [63:0] o_pay;
    logic        o_last;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    hdr_t          mem_whdr;
    logic [63:0]   mem_wpay;
    hdr_t          rd_hdr;
    logic [63:0]   rd_pay;

    logic        hit;
    logic [63:0] emit_pay;
    logic        s_accept;
    logic        slot_v;
    logic        later_valid;
    logic [7:0]  tick_inc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign len_clamp = (s_data_len > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : s_data_len;
    assign slot_v    = valid_reg[cmp_idx_reg];
    assign later_valid = |((valid_reg >> addr_reg) >> 1);
    assign tick_inc  = tick_reg + 8'd1;

    dedb_slot_mem #(.SLOTS(SLOTS)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .whdr  (mem_whdr),
        .wpay  (mem_wpay),
        .raddr (addr_reg),
        .rhdr  (rd_hdr),
        .rpay  (rd_pay)
    );

    dedb_match u_match (
        .key_lev  (in_lev_reg),
        .key_mod  (in_mod_reg),
        .key_func (in_func_reg),
        .key_pay  (in_pay_reg),
        .st_hdr   (rd_hdr),
        .st_pay   (rd_pay),
        .hit      (hit),
        .emit_pay (emit_pay)
    );

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        used_next       = used_reg;
        tick_next       = tick_reg;
        res_kind_next   = res_kind_reg;
        mem_we          = 1'b0;
        mem_waddr       = LAST_IDX;
        mem_whdr        = '0;
        mem_wpay        = '0;
        out_load        = 1'b0;
        o_kind          = res_kind_reg;
        o_hdr           = '0;
        o_pay           = '0;
        o_last          = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (!s_op) begin
                        if (used_reg >= LAST_IDX) begin
                            // table full: load the overflow marker into the reserved slot
                            mem_we        = 1'b1;
                            mem_waddr     = LAST_IDX;
                            mem_whdr      = '{len: OVF_LEN, func: OVF_FUNC,
                                              modl: ovf_mod_reg, lev: ovf_lev_reg};
                            mem_wpay      = OVF_PAY;
                            valid_next[LAST_IDX] = 1'b1;
                            res_kind_next = KIND_FULL;
                            state_next    = ST_RESP;
                        end else begin
                            addr_next       = '0;
                            cmp_vld_next    = 1'b0;
                            free_found_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    end else begin
                        if (tick_inc >= period_reg) begin
                            tick_next = '0;
                            if (s_link_ready && (used_reg != '0)) begin
                                addr_next  = '0;
                                state_next = ST_FRD;
                            end else begin
                                res_kind_next = KIND_IDLE;
                                state_next    = ST_RESP;
                            end
                        end else begin
                            tick_next     = tick_inc;
                            res_kind_next = KIND_IDLE;
                            state_next    = ST_RESP;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // read of addr_reg issued now, compare of the slot read last cycle
                cmp_idx_next = addr_reg;
                cmp_vld_next = 1'b1;
                if (addr_reg != LAST_IDX) begin
                    addr_next = addr_reg + 1'b1;
                end
                if (cmp_vld_reg) begin
                    if (slot_v && hit) begin
                        res_kind_next = KIND_DUP;
                        state_next    = ST_RESP;
                    end else begin
                        if (!slot_v && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == SCAN_END) begin
                            if (free_found_reg || !slot_v) begin
                                mem_we    = 1'b1;
                                mem_waddr = free_found_reg ? free_idx_reg : cmp_idx_reg;
                                mem_whdr  = '{len: in_len_reg, func: in_func_reg,
                                              modl: in_mod_reg, lev: in_lev_reg};
                                mem_wpay  = in_pay_reg & byte_mask(in_len_reg);
                                valid_next[mem_waddr] = 1'b1;
                                used_next     = used_reg + 1'b1;
                                res_kind_next = KIND_STORED;
                            end else begin
                                res_kind_next = KIND_FULL;
                            end
                            state_next = ST_RESP;
                        end
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FRD: begin
                if (valid_reg[addr_reg]) begin
                    state_next = ST_FEM;
                end else if (addr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_FEM: begin
                if (out_free) begin
                    out_load = 1'b1;
                    o_kind   = KIND_EMIT;
                    o_hdr    = rd_hdr;
                    o_pay    = emit_pay;
                    o_last   = !later_valid;
                    valid_next[addr_reg] = 1'b0;
                    // clearing the overflow slot leaves the count alone
                    if ((addr_reg != LAST_IDX) && (used_reg != '0)) begin
                        used_next = used_reg - 1'b1;
                    end
                    if (!later_valid) begin
                        state_next = ST_IDLE;
                    end else begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = ST_FRD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            addr_reg       <= '0;
            cmp_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            valid_reg      <= '0;
            used_reg       <= '0;
            tick_reg       <= '0;
            res_kind_reg   <= KIND_IDLE;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            cmp_idx_reg    <= cmp_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            valid_reg      <= valid_next;
            used_reg       <= used_next;
            tick_reg       <= tick_next;
            res_kind_reg   <= res_kind_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= FLUSH_PERIOD_RST;
            ovf_lev_reg <= OVF_LEVEL_RST;
            ovf_mod_reg <= OVF_MODULE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FLUSH_PERIOD: period_reg  <= cfg_data;
                CFG_OVF_LEVEL:    ovf_lev_reg <= cfg_data;
                CFG_OVF_MODULE:   ovf_mod_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_lev_reg  <= s_level;
            in_mod_reg  <= s_module_req;
            in_func_reg <= s_func_code;
            in_len_reg  <= len_clamp;
            in_pay_reg  <= s_payload;
        end
        if (out_load) begin
            m_kind_reg <= o_kind;
            m_hdr_reg  <= o_hdr;
            m_pay_reg  <= o_pay;
            m_last_reg <= o_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_out_level   = m_hdr_reg.lev;
    assign m_out_module  = m_hdr_reg.modl;
    assign m_out_func    = m_hdr_reg.func;
    assign m_out_len     = m_hdr_reg.len;
    assign m_out_payload = m_pay_reg;
    assign m_last        = m_last_reg;

endmodule
